[rtl/dfrm_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the
// resampling mixer. No dependencies.

package dfrm_pkg;

  localparam int DEPTH          = 1024;
  localparam int STEP_FRAC_BITS = 16;

  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 20;
  localparam int FILL_W   = 33;

  localparam logic [STEP_W-1:0] READ_STEP_RESET = 20'd65536;
  localparam logic [FILL_W-1:0] FILL_TOP        = 33'h0_FFFF_FFFF;

  // item kinds carried on tuser
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_MIX  = 1'b1;

  typedef struct packed {
    logic clear_step;  // write one zero row of the sweep
    logic push;        // store a sample, bump index and count
    logic mix_start;   // latch mix inputs, launch pair read
    logic mix_finish;  // load output register, update position and count
  } cmd_t;

  typedef struct packed {
    logic clear_last;  // sweep is on its last row
    logic out_free;    // output register can take a result this cycle
  } status_t;

endpackage

[rtl/dfrm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module dfrm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/dfrm_ctrl.sv]
// Controller FSM: clear sweep after reset, item dispatch, mix completion.
// Depends on dfrm_pkg.

module dfrm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_func,
  output logic               in_ready,
  input  dfrm_pkg::status_t  status,
  output dfrm_pkg::cmd_t     cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_MIX   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.clear_step = (state == ST_CLEAR);
    cmd.push       = in_ready && in_valid && (in_func == dfrm_pkg::FUNC_PUSH);
    cmd.mix_start  = in_ready && in_valid && (in_func == dfrm_pkg::FUNC_MIX);
    cmd.mix_finish = (state == ST_MIX) && status.out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.mix_start) state_next = ST_MIX;
      end
      ST_MIX: begin
        if (cmd.mix_finish) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/dfrm_datapath.sv]
// Datapath: even/odd sample banks, write index, read position, fill count,
// averaging and output register. Depends on dfrm_pkg and dfrm_ram.

module dfrm_datapath #(
  parameter int DEPTH          = dfrm_pkg::DEPTH,
  parameter int STEP_FRAC_BITS = dfrm_pkg::STEP_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dfrm_pkg::cmd_t                 cmd,
  output dfrm_pkg::status_t              status,
  input  logic                           cfg_we,
  input  logic [dfrm_pkg::STEP_W-1:0]    cfg_wdata,
  input  logic [dfrm_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [dfrm_pkg::SAMPLE_W-1:0]  in_mix_left,
  input  logic [dfrm_pkg::SAMPLE_W-1:0]  in_mix_right,
  input  logic                           in_batch_end,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dfrm_pkg::SAMPLE_W-1:0]  out_left,
  output logic [dfrm_pkg::SAMPLE_W-1:0]  out_right,
  output logic                           out_mixed
);

  localparam int SW     = dfrm_pkg::SAMPLE_W;
  localparam int FW     = dfrm_pkg::FILL_W;
  localparam int STW    = dfrm_pkg::STEP_W;
  localparam int FRAC   = STEP_FRAC_BITS;
  localparam int AW     = $clog2(DEPTH);
  localparam int BW     = AW - 1;           // row address of one bank
  localparam int ROWS   = DEPTH / 2;
  localparam int POS_W  = AW + FRAC;
  localparam int SUM_W  = ((POS_W > STW) ? POS_W : STW) + 1;
  localparam logic [FW-1:0] ONE_SAMPLE = FW'(64'd1 << STEP_FRAC_BITS);
  localparam logic [FW-1:0] PUSH_LIMIT = dfrm_pkg::FILL_TOP - ONE_SAMPLE;

  logic [STW-1:0]   read_step;
  logic [AW-1:0]    write_index;
  logic [POS_W-1:0] read_position;
  logic [FW-1:0]    fill_count;
  logic [BW-1:0]    clear_row;

  logic [SW-1:0]    mix_left;
  logic [SW-1:0]    mix_right;
  logic             batch_end;

  logic             we_even, we_odd;
  logic [BW-1:0]    waddr;
  logic [SW-1:0]    wdata;
  logic [BW-1:0]    raddr;
  logic [SW-1:0]    rd_even, rd_odd;

  logic [SUM_W-1:0] pos_sum;
  logic [POS_W-1:0] pos_adv;
  logic [POS_W-1:0] pos_next;
  logic [FW-1:0]    fill_mixed;
  logic [FW-1:0]    fill_next;
  logic             can_mix;
  logic [SW:0]      sum_l, sum_r, adj_l, adj_r;

  // bank write/read steering; pair i0 (even) and i0+1 (odd) share one row
  always_comb begin
    we_even = 1'b0;
    we_odd  = 1'b0;
    waddr   = write_index[AW-1:1];
    wdata   = in_sample;
    if (cmd.clear_step) begin
      we_even = 1'b1;
      we_odd  = 1'b1;
      waddr   = clear_row;
      wdata   = '0;
    end else if (cmd.push) begin
      we_even = ~write_index[0];
      we_odd  = write_index[0];
    end
  end

  assign raddr = read_position[POS_W-1:FRAC+1];

  dfrm_ram #(.WIDTH(SW), .DEPTH(ROWS)) u_bank_even (
    .clk(clk), .we(we_even), .waddr(waddr), .wdata(wdata),
    .re(cmd.mix_start), .raddr(raddr), .rdata(rd_even)
  );

  dfrm_ram #(.WIDTH(SW), .DEPTH(ROWS)) u_bank_odd (
    .clk(clk), .we(we_odd), .waddr(waddr), .wdata(wdata),
    .re(cmd.mix_start), .raddr(raddr), .rdata(rd_odd)
  );

  assign status.clear_last = (clear_row == BW'(ROWS - 1));
  assign status.out_free   = ~out_valid | out_ready;

  // average, truncated toward zero: add one to negative sums before halving
  always_comb begin
    sum_l = {mix_left[SW-1], mix_left} + {rd_even[SW-1], rd_even};
    sum_r = {mix_right[SW-1], mix_right} + {rd_odd[SW-1], rd_odd};
    adj_l = sum_l + {{SW{1'b0}}, sum_l[SW]};
    adj_r = sum_r + {{SW{1'b0}}, sum_r[SW]};
  end

  // position/count update at the end of a mix
  always_comb begin
    can_mix    = ~fill_count[FW-1];
    pos_sum    = SUM_W'(read_position) + SUM_W'(read_step);
    pos_adv    = can_mix ? pos_sum[POS_W-1:0] : read_position;
    fill_mixed = can_mix ? (fill_count - FW'(read_step)) : fill_count;
    pos_next   = pos_adv;
    fill_next  = fill_mixed;
    if (batch_end) begin
      pos_next = {pos_adv[POS_W-1:FRAC+1], {(FRAC+1){1'b0}}};
      if (!fill_mixed[FW-1] && (fill_mixed != '0)) begin
        fill_next = {fill_mixed[FW-1:FRAC], {FRAC{1'b0}}};
      end else begin
        fill_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_step     <= dfrm_pkg::READ_STEP_RESET;
      write_index   <= '0;
      read_position <= '0;
      fill_count    <= '0;
      clear_row     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) read_step <= cfg_wdata;
      if (cmd.clear_step) clear_row <= clear_row + BW'(1);
      if (cmd.push) begin
        write_index <= write_index + AW'(1);
        if ($signed(fill_count) > $signed(PUSH_LIMIT)) begin
          fill_count <= dfrm_pkg::FILL_TOP;
        end else begin
          fill_count <= fill_count + ONE_SAMPLE;
        end
      end
      if (cmd.mix_finish) begin
        read_position <= pos_next;
        fill_count    <= fill_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.mix_start) begin
      mix_left  <= in_mix_left;
      mix_right <= in_mix_right;
      batch_end <= in_batch_end;
    end
    if (cmd.mix_finish) begin
      out_left  <= can_mix ? adj_l[SW:1] : mix_left;
      out_right <= can_mix ? adj_r[SW:1] : mix_right;
      out_mixed <= can_mix;
    end
  end

endmodule

[rtl/dac_fifo_rate_resampling_mixer.sv]
// Top level of the fractional-step resampling sample ring with stereo mix.
// Depends on dfrm_pkg, dfrm_ctrl, dfrm_datapath (and dfrm_ram below it).
//
// Usage:
//  - Input stream (s_axis_*): tuser selects the item kind, 0 = push one
//    sample into the ring, 1 = mix one stereo frame. tlast marks the last
//    mix frame of a batch (floors position to an even sample and the fill
//    count to a whole sample, or to zero when not positive).
//  - Output stream (m_axis_*): one transfer per mix item, none per push.
//    tuser is 1 when buffered audio was averaged in, 0 on pass-through.
//  - cfg_we/cfg_wdata load read_step (Q4.16 step, reset 1.0); write only
//    while no mix is in flight.
//  - Timing: a push completes on its input transfer. A mix first reads the
//    sample pair from the even/odd bank RAMs, then (in ST_MIX) averages it
//    into the output register, which raises m_axis_tvalid. No new item is
//    taken until the mix has loaded the output register.
//  - Reset: the ring is swept to zero, one row of both banks per cycle,
//    over all DEPTH/2 rows, with s_axis_tready low; cfg writes are still taken.
//  - Stall: a result waits in the output register; pushes go on, and a
//    further mix waits in ST_MIX, with s_axis_tready low, until the register frees up.
//  - DEPTH must be a power of two.

module dac_fifo_rate_resampling_mixer #(
  parameter int DEPTH          = dfrm_pkg::DEPTH,
  parameter int STEP_FRAC_BITS = dfrm_pkg::STEP_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata,      // read_step
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // sample[15:0], mix_left[31:16], mix_right[47:32]
  input  logic        s_axis_tuser,   // func
  input  logic        s_axis_tlast,   // batch_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_left[15:0], out_right[31:16]
  output logic        m_axis_tuser    // mixed
);

  dfrm_pkg::cmd_t    cmd;
  dfrm_pkg::status_t status;

  dfrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_func  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dfrm_datapath #(
    .DEPTH          (DEPTH),
    .STEP_FRAC_BITS (STEP_FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_sample    (s_axis_tdata[15:0]),
    .in_mix_left  (s_axis_tdata[31:16]),
    .in_mix_right (s_axis_tdata[47:32]),
    .in_batch_end (s_axis_tlast),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_left     (m_axis_tdata[15:0]),
    .out_right    (m_axis_tdata[31:16]),
    .out_mixed    (m_axis_tuser)
  );

endmodule
